FILE: rtl/acpm_pkg.sv
package acpm_pkg;

	localparam int unsigned GAIN_W = 32;
	localparam int unsigned ADDR_W = 3;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd1048576;

	// register select is paddr[2]
	localparam logic REG_VOLTAGE_GAIN = 1'b0;
	localparam logic REG_CURRENT_GAIN = 1'b1;

	typedef struct packed {
		logic [15:0] voltage_sample;
		logic [15:0] current_sample;
		logic        last_sample;
	} acpm_in_t;

	typedef struct packed {
		logic [30:0]        rms_voltage;
		logic [30:0]        rms_current;
		logic [46:0]        apparent_power;
		logic [46:0]        active_power;
		logic [46:0]        reactive_power;
		logic [15:0]        power_factor;
		logic [30:0]        voltage_peak_high;
		logic signed [31:0] voltage_peak_low;
		logic [30:0]        current_peak_high;
		logic signed [31:0] current_peak_low;
		logic [30:0]        voltage_peak_to_peak;
		logic [30:0]        current_peak_to_peak;
	} acpm_out_t;

	// closing sequence, run in this order
	typedef enum logic [5:0] {
		OP_V_NSQ, OP_V_SS, OP_V_SQRT, OP_V_GAIN, OP_V_DIV,
		OP_I_NSQ, OP_I_SS, OP_I_SQRT, OP_I_GAIN, OP_I_DIV,
		OP_VA, OP_P_NX, OP_P_SS, OP_P_GG, OP_P_GAIN, OP_P_DIV1, OP_P_DIV2,
		OP_VA_SQ, OP_W_SQ, OP_Q_SQRT, OP_PF_DIV,
		OP_VH_NX, OP_VL_NX, OP_VH_GAIN, OP_VH_DIV, OP_VL_GAIN, OP_VL_DIV,
		OP_IH_NX, OP_IL_NX, OP_IH_GAIN, OP_IH_DIV, OP_IL_GAIN, OP_IL_DIV
	} acpm_op_t;

	localparam acpm_op_t OP_FIRST = OP_V_NSQ;
	localparam acpm_op_t OP_FINAL = OP_IL_DIV;

	typedef struct packed {
		logic     acc;
		logic     start;
		acpm_op_t op;
		logic     emit;
	} acpm_cmd_t;

	typedef struct packed {
		logic done;
		logic out_busy;
	} acpm_stat_t;

endpackage

FILE: rtl/acpm_div.sv
module acpm_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] dividend,
	input  logic [63:0]  divisor,
	output logic [127:0] quot,
	output logic         done
);

	logic [127:0] q_q;
	logic [63:0]  r_q;
	logic [63:0]  d_q;
	logic [6:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [64:0]  trial;
	logic         ge;

	assign trial = {r_q, q_q[127]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= (divisor == 64'd0) ? 64'd1 : divisor;
		end else if (run_q) begin
			if (ge) begin
				r_q <= 64'(trial - {1'b0, d_q});
				q_q <= {q_q[126:0], 1'b1};
			end else begin
				r_q <= trial[63:0];
				q_q <= {q_q[126:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign done = done_q;

endmodule

FILE: rtl/acpm_sqrt.sv
module acpm_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] radicand,
	output logic [63:0]  root,
	output logic         done
);

	logic [127:0] x_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [67:0]  rem2;
	logic [67:0]  trial;
	logic [67:0]  diff;
	logic         ge;

	// two radicand bits per step
	assign rem2  = {rem_q, x_q[127:126]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem2 >= trial;
	assign diff  = rem2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q <= {x_q[125:0], 2'b00};
			if (ge) begin
				rem_q  <= diff[65:0];
				root_q <= {root_q[62:0], 1'b1};
			end else begin
				rem_q  <= rem2[65:0];
				root_q <= {root_q[62:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

FILE: rtl/acpm_ctrl.sv
module acpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                sample_last,
	output logic                stall,
	output acpm_pkg::acpm_cmd_t cmd,
	input  acpm_pkg::acpm_stat_t stat
);
	import acpm_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EMIT} state_t;

	state_t   state_q;
	acpm_op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_FIRST;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid && sample_last) begin
						state_q <= S_ISSUE;
						op_q    <= OP_FIRST;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.done) begin
						if (op_q == OP_FINAL) begin
							state_q <= S_EMIT;
						end else begin
							op_q    <= acpm_op_t'(6'(op_q + 6'd1));
							state_q <= S_ISSUE;
						end
					end
				end
				S_EMIT: begin
					if (!stat.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stall     = state_q != S_IDLE;
	assign cmd.acc   = sample_valid && !stall;
	assign cmd.start = state_q == S_ISSUE;
	assign cmd.op    = op_q;
	assign cmd.emit  = (state_q == S_EMIT) && !stat.out_busy;

endmodule

FILE: rtl/acpm_dp.sv
module acpm_dp #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acpm_pkg::acpm_cmd_t  cmd,
	output acpm_pkg::acpm_stat_t stat,
	input  acpm_pkg::acpm_in_t   sample,
	input  logic [31:0]          voltage_gain,
	input  logic [31:0]          current_gain,
	output logic                 result_valid,
	input  logic                 result_stall,
	output acpm_pkg::acpm_out_t  result
);
	import acpm_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned LOG_N = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned SUM_W = SAMPLE_BITS + LOG_N;
	localparam int unsigned SQ_W  = 2 * SAMPLE_BITS + LOG_N;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
	localparam logic [63:0] SAT31 = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SAT47 = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] MAG32 = 64'h0000_0000_8000_0000;
	localparam logic [63:0] PF_MAX = 64'd32768;

	// window accumulators
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       sv_q, si_q;
	logic [SQ_W-1:0]        ssv_q, ssi_q, scp_q;
	logic [SAMPLE_BITS-1:0] vmax_q, vmin_q, imax_q, imin_q;
	logic [SAMPLE_BITS-1:0] v, c;
	logic [2*SAMPLE_BITS-1:0] vv, cc, vc;

	assign v  = sample.voltage_sample[SAMPLE_BITS-1:0];
	assign c  = sample.current_sample[SAMPLE_BITS-1:0];
	assign vv = v * v;
	assign cc = c * c;
	assign vc = v * c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sv_q   <= '0;
			si_q   <= '0;
			ssv_q  <= '0;
			ssi_q  <= '0;
			scp_q  <= '0;
			vmax_q <= '0;
			imax_q <= '0;
			vmin_q <= '1;
			imin_q <= '1;
		end else if (cmd.emit) begin
			cnt_q  <= '0;
			sv_q   <= '0;
			si_q   <= '0;
			ssv_q  <= '0;
			ssi_q  <= '0;
			scp_q  <= '0;
			vmax_q <= '0;
			imax_q <= '0;
			vmin_q <= '1;
			imin_q <= '1;
		end else if (cmd.acc && (cnt_q < CNT_MAX)) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sv_q  <= sv_q + SUM_W'(v);
			si_q  <= si_q + SUM_W'(c);
			ssv_q <= ssv_q + SQ_W'(vv);
			ssi_q <= ssi_q + SQ_W'(cc);
			scp_q <= scp_q + SQ_W'(vc);
			if (v > vmax_q) vmax_q <= v;
			if (v < vmin_q) vmin_q <= v;
			if (c > imax_q) imax_q <= c;
			if (c < imin_q) imin_q <= c;
		end
	end

	logic [63:0] n64, sv64, si64, ssv64, ssi64, scp64, gv64, gi64;

	assign n64   = (cnt_q == '0) ? 64'd1 : 64'(cnt_q);
	assign sv64  = 64'(sv_q);
	assign si64  = 64'(si_q);
	assign ssv64 = 64'(ssv_q);
	assign ssi64 = 64'(ssi_q);
	assign scp64 = 64'(scp_q);
	assign gv64  = 64'(voltage_gain);
	assign gi64  = 64'(current_gain);

	// scratch and results
	logic [63:0]  a_q, b_q, g_q;
	logic [127:0] x_q, y_q;
	logic         neg_q;
	logic [30:0]  vr_q, ir_q, vh_q, ih_q;
	logic [46:0]  va_q, wmag_q, rc_q;
	logic [15:0]  pf_q;
	logic [31:0]  vm_q, im_q;

	logic [63:0]  ab_pos, ab_mag, pk_sum, dh, dl;
	logic [127:0] yx;
	logic [46:0]  ac;

	always_comb begin
		ab_pos = (a_q >= b_q) ? a_q - b_q : 64'd0;
		ab_mag = (a_q < b_q) ? b_q - a_q : a_q - b_q;
		pk_sum = (cmd.op == OP_VH_GAIN || cmd.op == OP_VL_GAIN) ? sv64 : si64;
		dh     = (a_q > pk_sum) ? a_q - pk_sum : 64'd0;
		dl     = (pk_sum > b_q) ? pk_sum - b_q : 64'd0;
		yx     = (x_q <= y_q) ? y_q - x_q : 128'd0;
		ac     = neg_q ? 47'd0 : wmag_q;
	end

	// unit select and operands
	logic         use_mul, use_div, use_sqrt;
	logic [63:0]  mul_a, mul_b, div_d;
	logic [127:0] div_x, sqrt_x;

	always_comb begin
		use_mul  = 1'b0;
		use_div  = 1'b0;
		use_sqrt = 1'b0;
		unique case (cmd.op) inside
			OP_V_SQRT, OP_I_SQRT, OP_Q_SQRT: use_sqrt = 1'b1;
			OP_V_DIV, OP_I_DIV, OP_P_DIV1, OP_P_DIV2, OP_PF_DIV,
			OP_VH_DIV, OP_VL_DIV, OP_IH_DIV, OP_IL_DIV: use_div = 1'b1;
			default: use_mul = 1'b1;
		endcase
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		div_x  = x_q;
		div_d  = n64;
		sqrt_x = '0;
		case (cmd.op)
			OP_V_NSQ:   begin mul_a = n64;  mul_b = ssv64; end
			OP_V_SS:    begin mul_a = sv64; mul_b = sv64; end
			OP_V_SQRT:  sqrt_x = {ab_pos, 64'd0};
			OP_V_GAIN:  begin mul_a = gv64; mul_b = a_q; end
			OP_I_NSQ:   begin mul_a = n64;  mul_b = ssi64; end
			OP_I_SS:    begin mul_a = si64; mul_b = si64; end
			OP_I_SQRT:  sqrt_x = {ab_pos, 64'd0};
			OP_I_GAIN:  begin mul_a = gi64; mul_b = a_q; end
			OP_VA:      begin mul_a = 64'(vr_q); mul_b = 64'(ir_q); end
			OP_P_NX:    begin mul_a = n64;  mul_b = scp64; end
			OP_P_SS:    begin mul_a = sv64; mul_b = si64; end
			OP_P_GG:    begin mul_a = gv64; mul_b = gi64; end
			OP_P_GAIN:  begin mul_a = g_q;  mul_b = ab_mag; end
			OP_VA_SQ:   begin mul_a = 64'(va_q); mul_b = 64'(va_q); end
			OP_W_SQ:    begin mul_a = 64'(wmag_q); mul_b = 64'(wmag_q); end
			OP_Q_SQRT:  sqrt_x = yx;
			OP_PF_DIV:  begin div_x = 128'({ac, 15'd0}); div_d = 64'(va_q); end
			OP_VH_NX:   begin mul_a = n64;  mul_b = 64'(vmax_q); end
			OP_VL_NX:   begin mul_a = n64;  mul_b = 64'(vmin_q); end
			OP_VH_GAIN: begin mul_a = gv64; mul_b = dh; end
			OP_VL_GAIN: begin mul_a = gv64; mul_b = dl; end
			OP_IH_NX:   begin mul_a = n64;  mul_b = 64'(imax_q); end
			OP_IL_NX:   begin mul_a = n64;  mul_b = 64'(imin_q); end
			OP_IH_GAIN: begin mul_a = gi64; mul_b = dh; end
			OP_IL_GAIN: begin mul_a = gi64; mul_b = dl; end
			default: ;
		endcase
	end

	// 64x64 multiply, one 32x32 partial product per cycle
	logic [63:0]  ma_q, mb_q, mpp_s1;
	logic [127:0] macc_q;
	logic [1:0]   msh_s1;
	logic         mpv_s1;
	logic [2:0]   midx_q;
	logic         mrun_q, mdone_q;
	logic [31:0]  ma_part, mb_part;

	assign ma_part = midx_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign mb_part = midx_q[0] ? mb_q[63:32] : mb_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q  <= 1'b0;
			mdone_q <= 1'b0;
			mpv_s1  <= 1'b0;
			midx_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.start && use_mul) begin
				mrun_q <= 1'b1;
				midx_q <= '0;
				mpv_s1 <= 1'b0;
			end else if (mrun_q) begin
				mpv_s1 <= midx_q != 3'd4;
				if (midx_q != 3'd4) begin
					midx_q <= midx_q + 3'd1;
				end else begin
					mrun_q  <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && use_mul) begin
			ma_q   <= mul_a;
			mb_q   <= mul_b;
			macc_q <= '0;
		end else if (mrun_q) begin
			if (midx_q != 3'd4) begin
				mpp_s1 <= ma_part * mb_part;
				msh_s1 <= {1'b0, midx_q[1]} + {1'b0, midx_q[0]};
			end
			if (mpv_s1) macc_q <= macc_q + (128'(mpp_s1) << {msh_s1, 5'd0});
		end
	end

	logic [127:0] div_q;
	logic         div_done;
	logic [63:0]  sq_root;
	logic         sq_done;

	acpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start && use_div),
		.dividend (div_x),
		.divisor  (div_d),
		.quot     (div_q),
		.done     (div_done)
	);

	acpm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start && use_sqrt),
		.radicand (sqrt_x),
		.root     (sq_root),
		.done     (sq_done)
	);

	// shift and saturate
	logic [127:0] sat_in, sat_sh_val;
	logic [6:0]   sat_sh;
	logic [63:0]  sat_max, sat_out;

	always_comb begin
		sat_in  = (cmd.op == OP_Q_SQRT) ? 128'(sq_root) : div_q;
		sat_sh  = 7'd0;
		sat_max = '1;
		case (cmd.op) inside
			OP_V_DIV, OP_I_DIV:   begin sat_sh = 7'd36; sat_max = SAT31; end
			OP_P_DIV2:            begin sat_sh = 7'd24; sat_max = SAT47; end
			OP_PF_DIV:            sat_max = PF_MAX;
			OP_Q_SQRT:            sat_max = SAT47;
			OP_VH_DIV, OP_IH_DIV: begin sat_sh = 7'd4; sat_max = SAT31; end
			OP_VL_DIV, OP_IL_DIV: begin sat_sh = 7'd4; sat_max = MAG32; end
			default: ;
		endcase
		sat_sh_val = sat_in >> sat_sh;
		sat_out = (sat_sh_val[127:64] != 64'd0 || sat_sh_val[63:0] > sat_max) ?
			sat_max : sat_sh_val[63:0];
	end

	logic unit_done;
	assign unit_done = mdone_q || div_done || sq_done;

	always_ff @(posedge clk) begin
		if (unit_done) begin
			case (cmd.op)
				OP_V_NSQ, OP_I_NSQ, OP_P_NX, OP_VH_NX, OP_IH_NX: a_q <= macc_q[63:0];
				OP_V_SS, OP_I_SS, OP_P_SS, OP_VL_NX, OP_IL_NX:   b_q <= macc_q[63:0];
				OP_V_SQRT, OP_I_SQRT: a_q <= sq_root;
				OP_V_GAIN, OP_I_GAIN, OP_VH_GAIN, OP_VL_GAIN,
				OP_IH_GAIN, OP_IL_GAIN, OP_W_SQ: x_q <= macc_q;
				OP_V_DIV:  vr_q <= sat_out[30:0];
				OP_I_DIV:  ir_q <= sat_out[30:0];
				OP_VA:     va_q <= macc_q[62:16];
				OP_P_GG:   g_q <= macc_q[63:0];
				OP_P_GAIN: begin
					x_q   <= macc_q;
					neg_q <= a_q < b_q;
				end
				OP_P_DIV1: x_q <= div_q;
				OP_P_DIV2: wmag_q <= sat_out[46:0];
				OP_VA_SQ:  y_q <= macc_q;
				OP_Q_SQRT: rc_q <= sat_out[46:0];
				OP_PF_DIV: pf_q <= (neg_q || va_q == 47'd0) ? 16'd0 : sat_out[15:0];
				OP_VH_DIV: vh_q <= sat_out[30:0];
				OP_VL_DIV: vm_q <= sat_out[31:0];
				OP_IH_DIV: ih_q <= sat_out[30:0];
				OP_IL_DIV: im_q <= sat_out[31:0];
				default: ;
			endcase
		end
	end

	// result register
	acpm_out_t res_q;
	logic      res_valid_q;
	logic [32:0] vpp, ipp;

	assign vpp = {2'b00, vh_q} + {1'b0, vm_q};
	assign ipp = {2'b00, ih_q} + {1'b0, im_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.rms_voltage          <= vr_q;
			res_q.rms_current          <= ir_q;
			res_q.apparent_power       <= va_q;
			res_q.active_power         <= ac;
			res_q.reactive_power       <= rc_q;
			res_q.power_factor         <= pf_q;
			res_q.voltage_peak_high    <= vh_q;
			res_q.voltage_peak_low     <= ~vm_q + 32'd1;
			res_q.current_peak_high    <= ih_q;
			res_q.current_peak_low     <= ~im_q + 32'd1;
			res_q.voltage_peak_to_peak <= (vpp > 33'(SAT31)) ? SAT31[30:0] : vpp[30:0];
			res_q.current_peak_to_peak <= (ipp > 33'(SAT31)) ? SAT31[30:0] : ipp[30:0];
		end
	end

	assign result_valid  = res_valid_q;
	assign result        = res_q;
	assign stat.done     = unit_done;
	assign stat.out_busy = res_valid_q && result_stall;

endmodule

FILE: rtl/ac_power_metering_top.sv
// AC power meter. Raw voltage and current ADC counts arrive as pairs on the sample channel and
// are summed at one pair per cycle (count, sums, squares, cross product, raw min and max). The
// pair marked last closes the window: the sample channel stalls while the sequencer runs 33
// steps over shared units, mostly nine 128-step restoring divisions, three 64-step square
// roots and 21 multiplies of four 32x32 partial products; the stall grows while a previous
// result is still held. The result beat then carries RMS values, apparent, active and
// reactive power, power factor and the mean-removed peaks, and the window clears. A finished
// result may wait in its output register while the next window accumulates. Gains are Q12.20
// registers at 0x0 and 0x4.
module ac_power_metering_top #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [acpm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  acpm_pkg::acpm_in_t            sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output acpm_pkg::acpm_out_t           result
);
	import acpm_pkg::*;

	logic [GAIN_W-1:0] vgain_q, igain_q;
	acpm_cmd_t         cmd;
	acpm_stat_t        stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vgain_q <= GAIN_RESET;
			igain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_VOLTAGE_GAIN: vgain_q <= pwdata;
				REG_CURRENT_GAIN: igain_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_VOLTAGE_GAIN: prdata = vgain_q;
			REG_CURRENT_GAIN: prdata = igain_q;
			default:          prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	acpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_last  (sample.last_sample),
		.stall        (sample_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	acpm_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.voltage_gain (vgain_q),
		.current_gain (igain_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: rtl/acpm_checker.sv
module acpm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pready,
	input logic                sample_valid,
	input logic                sample_stall,
	input acpm_pkg::acpm_in_t  sample,
	input logic                result_valid,
	input logic                result_stall,
	input acpm_pkg::acpm_out_t result
);
	import acpm_pkg::*;

	// a held result beat keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// the closing beat starts the sequencer, so the next beat waits
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && sample.last_sample |=> sample_stall)
		else $error("sample taken right after closing beat");

	a_pf_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.power_factor <= 16'd32768)
		else $error("power factor above one");

	a_pf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.active_power == 47'd0 |-> result.power_factor == 16'd0)
		else $error("power factor without active power");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ac_power_metering_top acpm_checker u_chk (.*);
